@@ hdl/tmc_pkg.sv @@
package tmc_pkg;

    // USB-MIDI code index numbers and MIDI status nibbles
    localparam logic [3:0] HDR_CC       = 4'hB;
    localparam logic [3:0] HDR_PB       = 4'hE;
    localparam logic [7:0] MSG_CC       = 8'hB0;
    localparam logic [7:0] MSG_PB       = 8'hE0;
    localparam logic [7:0] CTRL_VOL_MSB = 8'd7;
    localparam logic [7:0] CTRL_VOL_LSB = 8'd39;

    localparam logic [6:0]  VOL_RESET     = 7'd64;
    localparam logic [6:0]  VOL_MAX       = 7'd127;
    localparam logic [15:0] PITCH_CENTRE  = 16'd8192;
    localparam logic [15:0] PITCH_LIMIT   = 16'd16384;
    localparam logic [15:0] PITCH_FLOOR   = 16'd128;
    localparam logic [15:0] PITCH_UP      = 16'd128;
    localparam logic [15:0] PITCH_DOWN    = 16'd129;
    localparam logic [6:0]  PITCH_HOLD    = 7'd100;

    // configuration register indexes and reset values
    localparam logic [1:0]  CFG_VOL_HOLD  = 2'd0;
    localparam logic [1:0]  CFG_THRESHOLD = 2'd1;
    localparam logic [1:0]  CFG_CHANNEL   = 2'd2;
    localparam logic [15:0] VOL_HOLD_RESET  = 16'd10;
    localparam logic [14:0] THRESHOLD_RESET = 15'd200;
    localparam logic [3:0]  CHANNEL_RESET   = 4'd0;

    // one classified sample, waiting for its packets to go out
    typedef struct packed {
        logic        vol_chg;
        logic        pit_chg;
        logic [6:0]  volume;
        logic [15:0] pitch;
        logic [3:0]  channel;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

@@ hdl/tmc_front.sv @@
module tmc_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [15:0]    s_accel_x,
    input  logic signed [15:0]    s_accel_y,
    input  logic [15:0]           volume_hold_ticks,
    input  logic [14:0]           tilt_threshold,
    input  logic [3:0]            midi_channel,
    input  tmc_pkg::queue_status_t q_status,
    output logic                  push,
    output tmc_pkg::job_t         push_job
);

    logic [6:0]  volume_reg, volume_next;
    logic [15:0] vol_hold_reg, vol_hold_next;
    logic [15:0] pitch_reg, pitch_next;
    logic [6:0]  pit_hold_reg, pit_hold_next;
    logic        vol_chg, pit_chg;
    logic        accept;

    logic [16:0] x_ext, x_mag, y_ext, y_mag, thr_ext;
    logic        x_over, y_over, x_neg, y_neg;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        x_ext   = {s_accel_x[15], s_accel_x};
        y_ext   = {s_accel_y[15], s_accel_y};
        x_neg   = s_accel_x[15];
        y_neg   = s_accel_y[15];
        x_mag   = x_neg ? (17'd0 - x_ext) : x_ext;
        y_mag   = y_neg ? (17'd0 - y_ext) : y_ext;
        thr_ext = {2'b00, tilt_threshold};
        x_over  = x_mag > thr_ext;
        y_over  = y_mag > thr_ext;
    end

    // volume axis
    always_comb begin
        volume_next   = volume_reg;
        vol_hold_next = vol_hold_reg;
        vol_chg       = 1'b0;
        if (vol_hold_reg != 16'd0) begin
            vol_hold_next = vol_hold_reg - 16'd1;
        end else if (x_neg) begin
            if (volume_reg != 7'd0 && x_over) begin
                volume_next   = volume_reg - 7'd1;
                vol_hold_next = volume_hold_ticks;
                vol_chg       = 1'b1;
            end
        end else if (s_accel_x != 16'sd0) begin
            if (volume_reg != tmc_pkg::VOL_MAX && x_over) begin
                volume_next   = volume_reg + 7'd1;
                vol_hold_next = volume_hold_ticks;
                vol_chg       = 1'b1;
            end
        end
    end

    // pitch axis; weak tilt recentres, a sample of exactly centre is ignored
    always_comb begin
        pitch_next    = pitch_reg;
        pit_hold_next = pit_hold_reg;
        pit_chg       = 1'b0;
        if (pit_hold_reg != 7'd0) begin
            pit_hold_next = pit_hold_reg - 7'd1;
        end else if (y_neg) begin
            if (pitch_reg >= tmc_pkg::PITCH_FLOOR) begin
                if (y_over) begin
                    pitch_next    = pitch_reg - tmc_pkg::PITCH_DOWN;
                    pit_hold_next = tmc_pkg::PITCH_HOLD;
                    pit_chg       = 1'b1;
                end else begin
                    pitch_next = tmc_pkg::PITCH_CENTRE;
                    pit_chg    = pitch_reg != tmc_pkg::PITCH_CENTRE;
                end
            end
        end else if ($unsigned(s_accel_y) == tmc_pkg::PITCH_CENTRE) begin
            pitch_next = pitch_reg;
        end else if (s_accel_y != 16'sd0) begin
            if (pitch_reg != tmc_pkg::PITCH_LIMIT) begin
                if (y_over) begin
                    pitch_next    = pitch_reg + tmc_pkg::PITCH_UP;
                    pit_hold_next = tmc_pkg::PITCH_HOLD;
                    pit_chg       = 1'b1;
                end else begin
                    pitch_next = tmc_pkg::PITCH_CENTRE;
                    pit_chg    = pitch_reg != tmc_pkg::PITCH_CENTRE;
                end
            end
        end else begin
            pitch_next = tmc_pkg::PITCH_CENTRE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_reg   <= tmc_pkg::VOL_RESET;
            vol_hold_reg <= 16'd0;
            pitch_reg    <= tmc_pkg::PITCH_CENTRE;
            pit_hold_reg <= 7'd0;
        end else if (accept) begin
            volume_reg   <= volume_next;
            vol_hold_reg <= vol_hold_next;
            pitch_reg    <= pitch_next;
            pit_hold_reg <= pit_hold_next;
        end
    end

    // samples that change nothing are not queued
    assign push             = accept && (vol_chg || pit_chg);
    assign push_job.vol_chg = vol_chg;
    assign push_job.pit_chg = pit_chg;
    assign push_job.volume  = volume_next;
    assign push_job.pitch   = pitch_next;
    assign push_job.channel = midi_channel;

endmodule

@@ hdl/tmc_queue.sv @@
module tmc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  tmc_pkg::job_t          push_job,
    input  logic                   pop,
    output tmc_pkg::job_t          head_job,
    output tmc_pkg::queue_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tmc_pkg::job_t  slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign status.full  = count_reg == CW'(DEPTH);
    assign status.empty = count_reg == '0;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ hdl/tmc_back.sv @@
module tmc_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tmc_pkg::job_t          head_job,
    input  tmc_pkg::queue_status_t q_status,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [3:0]             m_cable_header,
    output logic [7:0]             m_status_byte,
    output logic [7:0]             m_data_one,
    output logic [7:0]             m_data_two,
    output logic                   m_last
);

    typedef enum logic [1:0] {
        STEP_VOL_MSB,
        STEP_VOL_LSB,
        STEP_PITCH
    } step_t;

    step_t       step_reg, step_next, cur_step;
    logic        m_valid_reg, m_valid_next;
    logic [3:0]  header_reg, header_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  data_one_reg, data_one_next;
    logic [7:0]  data_two_reg, data_two_next;
    logic        last_reg, last_next;
    logic        load, is_last;

    // a job without a volume change starts at the pitch packet
    assign cur_step = (step_reg == STEP_VOL_MSB && !head_job.vol_chg) ? STEP_PITCH : step_reg;
    assign is_last  = (cur_step == STEP_PITCH)
                   || (cur_step == STEP_VOL_LSB && !head_job.pit_chg);
    assign load     = !q_status.empty && (!m_valid_reg || m_ready);
    assign pop      = load && is_last;

    always_comb begin
        header_next   = tmc_pkg::HDR_PB;
        status_next   = tmc_pkg::MSG_PB | {4'd0, head_job.channel};
        data_one_next = head_job.pitch[7:0];
        data_two_next = head_job.pitch[15:8];
        last_next     = is_last;
        step_next     = step_reg;
        case (cur_step)
            STEP_VOL_MSB: begin
                header_next   = tmc_pkg::HDR_CC;
                status_next   = tmc_pkg::MSG_CC | {4'd0, head_job.channel};
                data_one_next = tmc_pkg::CTRL_VOL_MSB;
                data_two_next = 8'd0;
                step_next     = STEP_VOL_LSB;
            end
            STEP_VOL_LSB: begin
                header_next   = tmc_pkg::HDR_CC;
                status_next   = tmc_pkg::MSG_CC | {4'd0, head_job.channel};
                data_one_next = tmc_pkg::CTRL_VOL_LSB;
                data_two_next = {1'b0, head_job.volume};
                step_next     = is_last ? STEP_VOL_MSB : STEP_PITCH;
            end
            STEP_PITCH: begin
                step_next = STEP_VOL_MSB;
            end
            default: begin
                step_next = STEP_VOL_MSB;
            end
        endcase
        if (!load) begin
            step_next = step_reg;
        end
        m_valid_next = load || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= STEP_VOL_MSB;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            header_reg   <= header_next;
            status_reg   <= status_next;
            data_one_reg <= data_one_next;
            data_two_reg <= data_two_next;
            last_reg     <= last_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_cable_header = header_reg;
    assign m_status_byte  = status_reg;
    assign m_data_one     = data_one_reg;
    assign m_data_two     = data_two_reg;
    assign m_last         = last_reg;

endmodule

@@ hdl/tilt_to_midi_controller.sv @@
// Channel  Ports                      Direction  Carries
// s_       valid/ready, accel_x/y     in         one accelerometer sample
// m_       valid/ready, header..last  out        one USB-MIDI packet
// cfg_     valid/ready, index, data   in         register write (hold, threshold, channel)
//
// A sample is classified in the cycle it is taken; the front takes one every cycle while
// the job queue has room. The packet sender puts out one packet per cycle while m_ready is
// high, so a sample costs 0 to 3 packets; the sustained rate is set by that sender.
// aresetn (synchronous, active low) restores levels, holds and registers; no sweep.
// A stalled m_ready fills the output register, then the job queue, then drops s_ready.
module tilt_to_midi_controller #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_cable_header,
    output logic [7:0]         m_status_byte,
    output logic [7:0]         m_data_one,
    output logic [7:0]         m_data_two,
    output logic               m_last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    logic [15:0] vol_hold_ticks_reg;
    logic [14:0] threshold_reg;
    logic [3:0]  channel_reg;

    tmc_pkg::job_t          push_job, head_job;
    tmc_pkg::queue_status_t q_status;
    logic                   push, pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vol_hold_ticks_reg <= tmc_pkg::VOL_HOLD_RESET;
            threshold_reg      <= tmc_pkg::THRESHOLD_RESET;
            channel_reg        <= tmc_pkg::CHANNEL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tmc_pkg::CFG_VOL_HOLD:  vol_hold_ticks_reg <= cfg_data;
                tmc_pkg::CFG_THRESHOLD: threshold_reg      <= cfg_data[14:0];
                tmc_pkg::CFG_CHANNEL:   channel_reg        <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    tmc_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_accel_x         (s_accel_x),
        .s_accel_y         (s_accel_y),
        .volume_hold_ticks (vol_hold_ticks_reg),
        .tilt_threshold    (threshold_reg),
        .midi_channel      (channel_reg),
        .q_status          (q_status),
        .push              (push),
        .push_job          (push_job)
    );

    tmc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    tmc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_job       (head_job),
        .q_status       (q_status),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cable_header (m_cable_header),
        .m_status_byte  (m_status_byte),
        .m_data_one     (m_data_one),
        .m_data_two     (m_data_two),
        .m_last         (m_last)
    );

`ifndef NO_ASSERTIONS
    // pitch bend always closes a sample's packets
    a_pitch_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cable_header == tmc_pkg::HDR_PB |-> m_last)
        else $error("pitch packet not marked last");

    // controller 7 is always followed by controller 39
    a_msb_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cable_header == tmc_pkg::HDR_CC && m_data_one == tmc_pkg::CTRL_VOL_MSB
        |-> !m_last && m_data_two == 8'd0)
        else $error("volume MSB packet malformed");

    a_msb_then_lsb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_cable_header == tmc_pkg::HDR_CC
        && m_data_one == tmc_pkg::CTRL_VOL_MSB
        |=> m_valid && m_cable_header == tmc_pkg::HDR_CC
        && m_data_one == tmc_pkg::CTRL_VOL_LSB && m_data_two <= 8'd127)
        else $error("volume LSB packet missing");
`endif

endmodule
